### rtl/crc32_pkg.sv
// Shared types, constants and CRC helper functions for the CRC-32 stream engine.
package crc32_pkg;

    localparam int CRC_WIDTH = 32;
    localparam int BYTE_WIDTH = 8;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POLYNOMIAL = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INITIAL_VALUE = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FINAL_XOR = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTPUT_BIG_ENDIAN = 3'd3;

    localparam logic [CRC_WIDTH-1:0] POLYNOMIAL_RESET = 32'h04C1_1DB7;
    localparam logic [CRC_WIDTH-1:0] INITIAL_VALUE_RESET = 32'hFFFF_FFFF;
    localparam logic [CRC_WIDTH-1:0] FINAL_XOR_RESET = 32'hFFFF_FFFF;
    localparam logic [CRC_WIDTH-1:0] CRC_REGISTER_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [CRC_WIDTH-1:0] poly_reflected;
        logic [CRC_WIDTH-1:0] initial_value;
        logic [CRC_WIDTH-1:0] final_xor;
        logic                 output_big_endian;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] data_byte;
        logic                  start_of_message;
        logic                  end_of_message;
    } item_t;

    function automatic logic [CRC_WIDTH-1:0] bit_reverse(input logic [CRC_WIDTH-1:0] v);
        logic [CRC_WIDTH-1:0] r;
        for (int i = 0; i < CRC_WIDTH; i++) begin
            r[i] = v[CRC_WIDTH-1-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_WIDTH-1:0] byte_swap(input logic [CRC_WIDTH-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Folds one byte into the register with eight LSB-first shift and XOR steps.
    function automatic logic [CRC_WIDTH-1:0] crc_byte_update(
        input logic [CRC_WIDTH-1:0]  crc,
        input logic [BYTE_WIDTH-1:0] data,
        input logic [CRC_WIDTH-1:0]  poly
    );
        logic [CRC_WIDTH-1:0] c;
        c = crc ^ {{(CRC_WIDTH-BYTE_WIDTH){1'b0}}, data};
        for (int k = 0; k < BYTE_WIDTH; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/crc32_cfg_regs.sv
// Configuration register file of the CRC-32 stream engine.
module crc32_cfg_regs
    import crc32_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CRC_WIDTH-1:0]       cfg_wdata,
    output cfg_t                       cfg
);

    logic [CRC_WIDTH-1:0] polynomial_reg;
    logic [CRC_WIDTH-1:0] initial_value_reg;
    logic [CRC_WIDTH-1:0] final_xor_reg;
    logic                 big_endian_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            polynomial_reg    <= POLYNOMIAL_RESET;
            initial_value_reg <= INITIAL_VALUE_RESET;
            final_xor_reg     <= FINAL_XOR_RESET;
            big_endian_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_POLYNOMIAL: begin
                    polynomial_reg <= cfg_wdata;
                end
                REG_INITIAL_VALUE: begin
                    initial_value_reg <= cfg_wdata;
                end
                REG_FINAL_XOR: begin
                    final_xor_reg <= cfg_wdata;
                end
                REG_OUTPUT_BIG_ENDIAN: begin
                    big_endian_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.poly_reflected    = bit_reverse(polynomial_reg);
    assign cfg.initial_value     = initial_value_reg;
    assign cfg.final_xor         = final_xor_reg;
    assign cfg.output_big_endian = big_endian_reg;

endmodule

### rtl/crc32_in_stage.sv
// Input register stage that holds one accepted item for the CRC core.
module crc32_in_stage
    import crc32_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    logic  valid_reg;
    item_t item_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

### rtl/crc32_core.sv
// Running CRC register, byte update logic and result register.
module crc32_core
    import crc32_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CRC_WIDTH-1:0] m_crc_value
);

    logic [CRC_WIDTH-1:0] crc_reg;
    logic [CRC_WIDTH-1:0] crc_next;
    logic [CRC_WIDTH-1:0] crc_base;
    logic [CRC_WIDTH-1:0] result_raw;
    logic [CRC_WIDTH-1:0] result_next;
    logic [CRC_WIDTH-1:0] result_reg;
    logic                 result_valid_reg;
    logic                 advance;

    // An item that ends a message waits until the result register is free.
    assign item_ready = !item.end_of_message || !result_valid_reg || m_ready;
    assign advance    = item_valid && item_ready;

    assign crc_base    = item.start_of_message ? cfg.initial_value : crc_reg;
    assign crc_next    = crc_byte_update(crc_base, item.data_byte, cfg.poly_reflected);
    assign result_raw  = crc_next ^ cfg.final_xor;
    assign result_next = cfg.output_big_endian ? byte_swap(result_raw) : result_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_REGISTER_RESET;
        end else if (advance) begin
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_valid_reg <= 1'b0;
        end else if (advance && item.end_of_message) begin
            result_valid_reg <= 1'b1;
        end else if (m_ready) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item.end_of_message) begin
            result_reg <= result_next;
        end
    end

    assign m_valid     = result_valid_reg;
    assign m_crc_value = result_reg;

endmodule

### rtl/crc32_stream_engine.sv
// Top level of the CRC-32 stream engine.
// The input channel (s_valid, s_ready) carries one message byte per item together with
// start and end of message flags. A start flag loads the initial value before the byte.
// The result channel (m_valid, m_ready) carries one CRC per message, after its last byte.
// Configuration registers are written through cfg_wr_en, cfg_index and cfg_wdata:
// polynomial, initial value, final XOR and output byte order. The user must write
// them only while no item is in flight; the block itself does not enforce this. The
// last byte of a message sits in the input register, where the byte update folds all
// eight bit steps into the running CRC combinationally; then the result register loads.
// Throughput is one item per cycle while no message end waits for the result register.
// Reset clears both stages, loads the running CRC register with all ones and restores
// the standard CRC-32 configuration.
// When the receiver stalls, bytes that do not end a message keep flowing; an item that
// ends a message waits in the input register until the result register is free, and
// s_ready falls once the input register is also occupied.
module crc32_stream_engine
    import crc32_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CRC_WIDTH-1:0]       cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [BYTE_WIDTH-1:0]      s_data_byte,
    input  logic                       s_start_of_message,
    input  logic                       s_end_of_message,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [CRC_WIDTH-1:0]       m_crc_value
);

    cfg_t  cfg;
    item_t s_item;
    item_t core_item;
    logic  core_valid;
    logic  core_ready;

    assign s_item.data_byte        = s_data_byte;
    assign s_item.start_of_message = s_start_of_message;
    assign s_item.end_of_message   = s_end_of_message;

    crc32_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    crc32_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_item  (core_item)
    );

    crc32_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .item_valid  (core_valid),
        .item_ready  (core_ready),
        .item        (core_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_crc_value (m_crc_value)
    );

endmodule

### bench/crc32_stream_engine_tb.sv
// Self-checking testbench for the CRC-32 stream engine, predicting each message CRC.
module crc32_stream_engine_tb;
    import crc32_pkg::*;

    localparam int NUM_CFG_REGS = 4;
    localparam int RANDOM_ITEMS = 950;
    localparam int QUIET_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS = 10;

    class crc_scoreboard;
        logic [CRC_WIDTH-1:0] poly_normal;
        logic [CRC_WIDTH-1:0] init_value;
        logic [CRC_WIDTH-1:0] xor_out;
        logic                 big_endian;
        logic [CRC_WIDTH-1:0] running_crc;
        logic [CRC_WIDTH-1:0] expected_crcs[$];
        int                   error_count;

        function new();
            poly_normal = POLYNOMIAL_RESET;
            init_value = INITIAL_VALUE_RESET;
            xor_out = FINAL_XOR_RESET;
            big_endian = 1'b0;
            running_crc = CRC_REGISTER_RESET;
            error_count = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] index, logic [CRC_WIDTH-1:0] value);
            case (index)
                REG_POLYNOMIAL: poly_normal = value;
                REG_INITIAL_VALUE: init_value = value;
                REG_FINAL_XOR: xor_out = value;
                REG_OUTPUT_BIG_ENDIAN: big_endian = value[0];
                default: ;
            endcase
        endfunction

        function void note_byte(logic [BYTE_WIDTH-1:0] data, logic sof, logic eof);
            logic [CRC_WIDTH-1:0] poly_lsb_first;
            logic [CRC_WIDTH-1:0] crc;
            for (int i = 0; i < CRC_WIDTH; i++) begin
                poly_lsb_first[i] = poly_normal[CRC_WIDTH-1-i];
            end
            if (sof) begin
                running_crc = init_value;
            end
            crc = running_crc ^ CRC_WIDTH'(data);
            for (int k = 0; k < BYTE_WIDTH; k++) begin
                crc = crc[0] ? ((crc >> 1) ^ poly_lsb_first) : (crc >> 1);
            end
            running_crc = crc;
            if (eof) begin
                crc = running_crc ^ xor_out;
                if (big_endian) begin
                    crc = {crc[7:0], crc[15:8], crc[23:16], crc[31:24]};
                end
                expected_crcs.push_back(crc);
            end
        endfunction

        function void flag_error(string msg);
            if (error_count < MAX_REPORTS) begin
                $display("ERROR at %0t: %s", $time, msg);
            end
            error_count++;
        endfunction

        function void check_crc(logic [CRC_WIDTH-1:0] actual);
            logic [CRC_WIDTH-1:0] expected;
            if (expected_crcs.size() == 0) begin
                flag_error($sformatf("unexpected crc_value %h", actual));
            end else begin
                expected = expected_crcs.pop_front();
                if (actual !== expected) begin
                    flag_error($sformatf("crc_value expected %h, got %h", expected, actual));
                end
            end
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CRC_WIDTH-1:0]       cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [BYTE_WIDTH-1:0]      s_data_byte = '0;
    logic                       s_start_of_message = 1'b0;
    logic                       s_end_of_message = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [CRC_WIDTH-1:0]       m_crc_value;

    crc_scoreboard crc_sb;
    int            items_sent = 0;
    int            burst_left = 0;
    bit            sender_steady = 1'b0;
    int            rx_cycle = 0;
    int            quiet_cycles = 0;

    crc32_stream_engine i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_start_of_message (s_start_of_message),
        .s_end_of_message   (s_end_of_message),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_crc_value        (m_crc_value)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                crc_sb.write_reg(cfg_index, cfg_wdata);
            end
            if (s_valid && s_ready) begin
                crc_sb.note_byte(s_data_byte, s_start_of_message, s_end_of_message);
            end
            if (m_valid && m_ready) begin
                crc_sb.check_crc(m_crc_value);
            end
        end
    end

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle >> 7) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (rx_cycle % 16) < 3;
            default: m_ready <= $urandom_range(0, 3) != 0;
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("crc32_stream_engine_tb: done, errors");
            $finish;
        end
    end

    task automatic send_byte(logic [BYTE_WIDTH-1:0] data, logic sof, logic eof);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!sender_steady) begin
                gap = $urandom_range(1, 8);
            end
        end
        burst_left--;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= data;
        s_start_of_message <= sof;
        s_end_of_message <= eof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Waits out every pending CRC and any byte still inside the pipeline.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (crc_sb.expected_crcs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_INDEX_WIDTH-1:0] index, logic [CRC_WIDTH-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic set_config(logic [CRC_WIDTH-1:0] poly, logic [CRC_WIDTH-1:0] init,
                              logic [CRC_WIDTH-1:0] fxor, logic [CRC_WIDTH-1:0] order);
        write_cfg(CFG_INDEX_WIDTH'(NUM_CFG_REGS + $urandom_range(0, 3)), $urandom);
        write_cfg(REG_POLYNOMIAL, poly);
        write_cfg(REG_INITIAL_VALUE, init);
        write_cfg(REG_FINAL_XOR, fxor);
        write_cfg(REG_OUTPUT_BIG_ENDIAN, order);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int random_goal;
        int phase_end;
        int phase;
        int msg_len;
        crc_sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A byte straight after reset continues from the all-ones register.
        sender_steady = 1'b1;
        send_byte(8'h00, 1'b0, 1'b1);
        for (int i = 0; i < 9; i++) begin
            send_byte(BYTE_WIDTH'(8'h31 + i), i == 0, i == 8);
        end
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h80, 1'b1, 1'b1);

        // Polynomial and initial value change while a message is open.
        send_byte(8'h01, 1'b1, 1'b0);
        drain_results();
        write_cfg(REG_POLYNOMIAL, 32'h1EDC_6F41);
        write_cfg(REG_INITIAL_VALUE, 32'h1234_5678);
        cfg_wr_en <= 1'b0;
        send_byte(8'h7F, 1'b0, 1'b1);
        send_byte(8'hAA, 1'b1, 1'b1);
        drain_results();

        set_config(32'h741B_8CD7, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h55, 1'b1, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b1);

        random_goal = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < random_goal) begin
            drain_results();
            case (phase % 6)
                0: set_config(POLYNOMIAL_RESET, INITIAL_VALUE_RESET, FINAL_XOR_RESET,
                              32'h0000_0000);
                1: set_config(32'h1EDC_6F41, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
                2: set_config(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, $urandom);
                3: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
                4: set_config(32'h741B_8CD7, $urandom, $urandom, $urandom);
                default: set_config($urandom, $urandom, $urandom, $urandom);
            endcase
            sender_steady = (phase % 4) == 3;
            phase_end = items_sent + $urandom_range(80, 140);
            if (phase_end > random_goal) begin
                phase_end = random_goal;
            end
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_byte(BYTE_WIDTH'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end else begin
                    msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                           : $urandom_range(1, 16);
                    for (int i = 0; i < msg_len; i++) begin
                        send_byte(BYTE_WIDTH'($urandom), i == 0, i == msg_len - 1);
                    end
                end
            end
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (crc_sb.error_count == 0) begin
            $display("crc32_stream_engine_tb: done, clean");
        end else begin
            $display("crc32_stream_engine_tb: done, errors");
        end
        $finish;
    end

endmodule

### files.f
rtl/crc32_pkg.sv
rtl/crc32_cfg_regs.sv
rtl/crc32_in_stage.sv
rtl/crc32_core.sv
rtl/crc32_stream_engine.sv
bench/crc32_stream_engine_tb.sv
